// File: hw/rtl/range_median_adaptive_ema_filter_defines.svh
// assertion macros for the range filter
`ifndef RANGE_MEDIAN_ADAPTIVE_EMA_FILTER_DEFINES_SVH
`define RANGE_MEDIAN_ADAPTIVE_EMA_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RMAF_ASSERT_IMP(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("rmaf check failed");

// next-cycle implication
`define RMAF_ASSERT_NXT(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("rmaf check failed");

`endif

// File: hw/rtl/rmaf_pkg.sv
package rmaf_pkg;

   localparam int RING_DEPTH      = 5;
   localparam int WARMUP_READINGS = 8;

   localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);
   localparam int WARM_W     = $clog2(WARMUP_READINGS + 1);

   localparam int RAW_W     = 16;
   localparam int TIME_W    = 32;
   localparam int RANGE_W   = 13;
   localparam int MIN_W     = 10;
   localparam int RUN_W     = 16;
   localparam int TMO_W     = 16;
   localparam int Q8_W      = 21;
   localparam int DIFF_W    = 23;
   localparam int SUM_W     = 24;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = DIFF_W + COEF_W + 1;
   localparam int STEADY_W  = 8;
   localparam int NUM_W     = Q8_W + WARM_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_MODE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RANGE   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_RANGE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STUCK_LIMIT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_STUCK_TMO   = 3'd4;

   localparam logic [1:0] SPEED_CONSERVATIVE = 2'd1;
   localparam logic [1:0] SPEED_FAST         = 2'd3;

   localparam logic [1:0]         RST_SPEED_MODE  = SPEED_FAST;
   localparam logic [RANGE_W-1:0] RST_MAX_RANGE   = 13'd3500;
   localparam logic [MIN_W-1:0]   RST_MIN_RANGE   = 10'd30;
   localparam logic [RUN_W-1:0]   RST_STUCK_LIMIT = 16'd50;
   localparam logic [TMO_W-1:0]   RST_STUCK_TMO   = 16'd5000;
   localparam logic [Q8_W-1:0]    RST_FILTER_Q8   = 21'd896000;

   localparam int STUCK_MARGIN   = 50;
   localparam int JUMP_DROP_Q8   = 6400;
   localparam int JUMP_NEAR_MM   = 1500;
   localparam int RISE_Q8        = 8960;
   localparam int RISE_CEIL_Q8   = 204800;
   localparam int CHG_EMA_Q8     = 17920;
   localparam int CHG_HI_Q8      = 5120;
   localparam int CHG_LO_Q8      = 768;
   localparam int CHG_STEADY_Q8  = 3840;
   localparam int STEADY_MAX     = 255;

   localparam logic [COEF_W-1:0] RISE_CONS  = 16'd58982;
   localparam logic [COEF_W-1:0] RISE_BAL   = 16'd62259;
   localparam logic [COEF_W-1:0] EMA_MID    = 16'd14418;
   localparam logic [COEF_W-1:0] EMA_HI     = 16'd22938;
   localparam logic [COEF_W-1:0] EMA_LO     = 16'd4588;
   localparam logic [COEF_W-1:0] REC_FAST   = 16'd27525;
   localparam logic [COEF_W-1:0] REC_CONS   = 16'd16056;
   localparam logic [COEF_W-1:0] REC_BAL    = 16'd20644;
   localparam logic [COEF_W-1:0] SLOW_CONS  = 16'd5243;
   localparam logic [COEF_W-1:0] SLOW_FAST  = 16'd11796;
   localparam logic [COEF_W-1:0] SLOW_BAL   = 16'd7864;

   localparam logic [TIME_W-1:0]   REC_TMO_CONS  = 32'd3500;
   localparam logic [TIME_W-1:0]   REC_TMO_FAST  = 32'd2000;
   localparam logic [TIME_W-1:0]   REC_TMO_BAL   = 32'd2500;
   localparam logic [STEADY_W-1:0] REC_NEED_CONS = 8'd6;
   localparam logic [STEADY_W-1:0] REC_NEED_FAST = 8'd3;
   localparam logic [STEADY_W-1:0] REC_NEED_BAL  = 8'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MEDIAN,
      ST_DECIDE,
      ST_DIVIDE,
      ST_MULT,
      ST_BLEND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [RAW_W-1:0]  raw_mm;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [Q8_W-1:0]    filtered_q8;
      logic [RANGE_W-1:0] median_mm;
      logic               stuck_warning;
      logic               sensor_reset;
      logic               warming_up;
   } rsp_type;

endpackage

// File: hw/rtl/range_median_adaptive_ema_filter.sv
// path from req accept to rsp_valid: a stuck reset goes from the check straight to
// the response; after warm-up a median scan of 1 to 5 steps, one multiply and one
// blend (an obstacle jump skips both); in warm-up a 26-step restoring divider forms
// the average unless the median is out of range. One item at a time, taken in idle.
// synchronous active-high reset loads the register defaults and empties the
// ring, filter state back to max range, no clearing pass
module range_median_adaptive_ema_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rmaf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rmaf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [rmaf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rmaf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rmaf_pkg::*;

`include "range_median_adaptive_ema_filter_defines.svh"

   state_type state_ff, state_in;

   logic [1:0]         mode_ff;
   logic [RANGE_W-1:0] max_ff;
   logic [MIN_W-1:0]   min_ff;
   logic [RUN_W-1:0]   lim_ff;
   logic [TMO_W-1:0]   tmo_ff;

   logic [RANGE_W-1:0]    ring_ff [RING_DEPTH];
   logic [RING_IDX_W-1:0] wpos_ff;
   logic [RING_CNT_W-1:0] vcnt_ff;
   logic [Q8_W-1:0]       filt_ff, stab_ff;
   logic [WARM_W-1:0]     warm_ff;
   logic                  recov_ff;
   logic [STEADY_W-1:0]   steady_ff;
   logic [TIME_W-1:0]     lct_ff, lvt_ff;
   logic [RUN_W-1:0]      nmr_ff;

   logic [RAW_W-1:0]      raw_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [RANGE_W-1:0]    med_ff;
   logic                  warn_ff, srst_ff;
   logic [RING_IDX_W-1:0] cand_ff;
   logic [NUM_W-1:0]      num_ff;
   logic [WARM_W-1:0]     rem_ff, den_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [COEF_W-1:0]        coef_ff;
   logic [Q8_W-1:0]          base_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // stuck check
   logic [RANGE_W-1:0] ref_mm, raw_clamp;
   logic [RUN_W-1:0]   nmr_inc;
   logic               near, over, expired, stuck_rst;

   always_comb begin
      ref_mm    = (max_ff >= RANGE_W'(STUCK_MARGIN)) ? max_ff - RANGE_W'(STUCK_MARGIN) : '0;
      near      = raw_ff >= {3'b0, ref_mm};
      nmr_inc   = (nmr_ff == '1) ? nmr_ff : nmr_ff + 1'b1;
      over      = nmr_inc > lim_ff;
      expired   = (now_ff - lvt_ff) > {16'b0, tmo_ff};
      stuck_rst = near && over && expired;
      raw_clamp = (raw_ff > {3'b0, max_ff}) ? max_ff : raw_ff[RANGE_W-1:0];
   end

   // median scan, one candidate per cycle
   logic [RANGE_W-1:0]    cand_val;
   logic [RING_CNT_W-1:0] less_cnt, eq_cnt, mid_rank;
   logic                  med_hit;

   always_comb begin
      cand_val = ring_ff[cand_ff];
      less_cnt = '0;
      eq_cnt   = '0;
      for (int j = 0; j < RING_DEPTH; j++) begin
         if (RING_CNT_W'(j) < vcnt_ff) begin
            if (ring_ff[j] < cand_val) less_cnt = less_cnt + 1'b1;
            if (ring_ff[j] == cand_val) eq_cnt = eq_cnt + 1'b1;
         end
      end
      mid_rank = vcnt_ff >> 1;
      med_hit  = (less_cnt <= mid_rank) && (mid_rank < less_cnt + eq_cnt);
   end

   // adaptive decision
   logic [Q8_W-1:0]          m_q8, chg;
   logic                     warm_act, in_range, obstacle, rise, ema;
   logic [COEF_W-1:0]        coef_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic [Q8_W-1:0]          base_in;
   logic [STEADY_W-1:0]      steady_inc;
   logic [NUM_W-1:0]         num_init;

   always_comb begin
      m_q8     = {med_ff, 8'b0};
      warm_act = warm_ff < WARM_W'(WARMUP_READINGS);
      in_range = (med_ff >= {3'b0, min_ff}) && (med_ff <= max_ff);
      obstacle = ({2'b0, m_q8} + DIFF_W'(JUMP_DROP_Q8) < {2'b0, stab_ff})
                 && (med_ff < RANGE_W'(JUMP_NEAR_MM));
      rise     = ({2'b0, m_q8} > {2'b0, stab_ff} + DIFF_W'(RISE_Q8))
                 && (stab_ff < Q8_W'(RISE_CEIL_Q8));
      chg      = (m_q8 > stab_ff) ? m_q8 - stab_ff : stab_ff - m_q8;
      ema      = chg <= Q8_W'(CHG_EMA_Q8);
      steady_inc = (steady_ff == STEADY_W'(STEADY_MAX)) ? steady_ff : steady_ff + 1'b1;
      num_init = NUM_W'(filt_ff) * NUM_W'(warm_ff) + NUM_W'(m_q8)
                 + NUM_W'((warm_ff + 1'b1) >> 1);
      base_in  = stab_ff;
      diff_in  = $signed({2'b0, m_q8}) - $signed({2'b0, stab_ff});
      coef_in  = EMA_MID;
      priority if (rise) begin
         if (mode_ff == SPEED_FAST) begin
            base_in = m_q8;
            diff_in = '0;
         end
         coef_in = (mode_ff == SPEED_CONSERVATIVE) ? RISE_CONS : RISE_BAL;
      end else if (ema) begin
         base_in = filt_ff;
         diff_in = $signed({2'b0, m_q8}) - $signed({2'b0, filt_ff});
         priority if (chg > Q8_W'(CHG_HI_Q8)) coef_in = EMA_HI;
         else if (chg < Q8_W'(CHG_LO_Q8)) coef_in = EMA_LO;
         else coef_in = EMA_MID;
         if (recov_ff && (m_q8 > filt_ff)) begin
            priority if (mode_ff == SPEED_FAST) coef_in = REC_FAST;
            else if (mode_ff == SPEED_CONSERVATIVE) coef_in = REC_CONS;
            else coef_in = REC_BAL;
         end
      end else begin
         priority if (mode_ff == SPEED_CONSERVATIVE) coef_in = SLOW_CONS;
         else if (mode_ff == SPEED_FAST) coef_in = SLOW_FAST;
         else coef_in = SLOW_BAL;
      end
   end

   // divider step
   logic [WARM_W:0]    rem_sh;
   logic               qbit;
   logic [WARM_W-1:0]  rem_nx;
   logic [NUM_W-1:0]   num_nx;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      qbit   = rem_sh >= {1'b0, den_ff};
      rem_nx = qbit ? WARM_W'(rem_sh - {1'b0, den_ff}) : rem_sh[WARM_W-1:0];
      num_nx = {num_ff[NUM_W-2:0], qbit};
   end

   // blend, recovery exit and clamp
   logic signed [PROD_W-1:0] rnd;
   logic signed [SUM_W-1:0]  fsum, maxq, minq, fclamp;
   logic [TIME_W-1:0]        rec_tmo;
   logic [STEADY_W-1:0]      rec_need;
   logic                     rec_exit;

   always_comb begin
      rnd  = (prod_ff + PROD_W'(32768)) >>> 16;
      fsum = $signed({3'b0, base_ff}) + $signed(rnd[SUM_W-1:0]);
      maxq = $signed({3'b0, max_ff, 8'b0});
      minq = $signed({6'b0, min_ff, 8'b0});
      fclamp = fsum;
      if (fclamp > maxq) fclamp = maxq;
      if (fclamp < minq) fclamp = minq;
      priority if (mode_ff == SPEED_CONSERVATIVE) begin
         rec_tmo  = REC_TMO_CONS;
         rec_need = REC_NEED_CONS;
      end else if (mode_ff == SPEED_FAST) begin
         rec_tmo  = REC_TMO_FAST;
         rec_need = REC_NEED_FAST;
      end else begin
         rec_tmo  = REC_TMO_BAL;
         rec_need = REC_NEED_BAL;
      end
      rec_exit = recov_ff && (((now_ff - lct_ff) > rec_tmo) || (steady_ff > rec_need));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = stuck_rst ? ST_RESP : ST_MEDIAN;
         ST_MEDIAN: if (med_hit) state_in = ST_DECIDE;
         ST_DECIDE: begin
            priority if (warm_act) state_in = in_range ? ST_DIVIDE : ST_RESP;
            else if (obstacle) state_in = ST_RESP;
            else state_in = ST_MULT;
         end
         ST_DIVIDE: if (cnt_ff == DIV_CNT_W'(1)) state_in = ST_RESP;
         ST_MULT:   state_in = ST_BLEND;
         ST_BLEND:  state_in = ST_RESP;
         ST_RESP:   if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_data.filtered_q8   = filt_ff;
      rsp_data.median_mm     = med_ff;
      rsp_data.stuck_warning = warn_ff;
      rsp_data.sensor_reset  = srst_ff;
      rsp_data.warming_up    = warm_ff < WARM_W'(WARMUP_READINGS);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= RST_SPEED_MODE;
         max_ff  <= RST_MAX_RANGE;
         min_ff  <= RST_MIN_RANGE;
         lim_ff  <= RST_STUCK_LIMIT;
         tmo_ff  <= RST_STUCK_TMO;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPEED_MODE:  mode_ff <= csr_wdata[1:0];
            CSR_MAX_RANGE:   max_ff  <= csr_wdata[RANGE_W-1:0];
            CSR_MIN_RANGE:   min_ff  <= csr_wdata[MIN_W-1:0];
            CSR_STUCK_LIMIT: lim_ff  <= csr_wdata[RUN_W-1:0];
            CSR_STUCK_TMO:   tmo_ff  <= csr_wdata[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) ring_ff[i] <= RST_MAX_RANGE;
         wpos_ff   <= '0;
         vcnt_ff   <= '0;
         filt_ff   <= RST_FILTER_Q8;
         stab_ff   <= RST_FILTER_Q8;
         warm_ff   <= '0;
         recov_ff  <= 1'b0;
         steady_ff <= '0;
         lct_ff    <= '0;
         nmr_ff    <= '0;
         lvt_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_CHECK: begin
               if (stuck_rst) begin
                  for (int i = 0; i < RING_DEPTH; i++) ring_ff[i] <= max_ff;
                  wpos_ff <= '0;
                  vcnt_ff <= '0;
                  filt_ff <= {max_ff, 8'b0};
                  nmr_ff  <= '0;
                  lvt_ff  <= now_ff;
               end else begin
                  if (near) nmr_ff <= nmr_inc;
                  else begin
                     nmr_ff <= '0;
                     lvt_ff <= now_ff;
                  end
                  ring_ff[wpos_ff] <= raw_clamp;
                  wpos_ff <= (wpos_ff == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
                  if (vcnt_ff < RING_CNT_W'(RING_DEPTH)) vcnt_ff <= vcnt_ff + 1'b1;
               end
            end
            ST_DECIDE: begin
               if (!warm_act) begin
                  priority if (obstacle) begin
                     recov_ff  <= 1'b0;
                     steady_ff <= '0;
                     filt_ff   <= m_q8;
                     stab_ff   <= m_q8;
                  end else if (rise) begin
                     recov_ff  <= 1'b1;
                     lct_ff    <= now_ff;
                     steady_ff <= '0;
                  end else if (ema) begin
                     steady_ff <= (chg < Q8_W'(CHG_STEADY_Q8)) ? steady_inc : '0;
                  end else begin
                     steady_ff <= '0;
                  end
               end
            end
            ST_DIVIDE: begin
               if (cnt_ff == DIV_CNT_W'(1)) begin
                  filt_ff <= num_nx[Q8_W-1:0];
                  stab_ff <= num_nx[Q8_W-1:0];
                  warm_ff <= warm_ff + 1'b1;
               end
            end
            ST_BLEND: begin
               if (rec_exit) recov_ff <= 1'b0;
               filt_ff <= fclamp[Q8_W-1:0];
               stab_ff <= fclamp[Q8_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            raw_ff <= req_data.raw_mm;
            now_ff <= req_data.now_ms;
         end
         ST_CHECK: begin
            warn_ff <= near && over;
            srst_ff <= stuck_rst;
            cand_ff <= '0;
            if (stuck_rst) med_ff <= '0;
         end
         ST_MEDIAN: begin
            if (med_hit) med_ff <= cand_val;
            cand_ff <= cand_ff + 1'b1;
         end
         ST_DECIDE: begin
            num_ff  <= num_init;
            rem_ff  <= '0;
            den_ff  <= warm_ff + 1'b1;
            cnt_ff  <= DIV_CNT_W'(NUM_W);
            diff_ff <= diff_in;
            coef_ff <= coef_in;
            base_ff <= base_in;
         end
         ST_DIVIDE: begin
            num_ff <= num_nx;
            rem_ff <= rem_nx;
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_MULT: prod_ff <= PROD_W'(diff_ff) * $signed({1'b0, coef_ff});
         default: ;
      endcase
   end

   `RMAF_ASSERT_IMP(a_one_side, rsp_valid, !req_ready)
   `RMAF_ASSERT_IMP(a_vcnt_bound, 1'b1, vcnt_ff <= RING_CNT_W'(RING_DEPTH))
   `RMAF_ASSERT_NXT(a_accept_check, req_valid && req_ready, state_ff == ST_CHECK)
   `RMAF_ASSERT_IMP(a_reset_item, rsp_valid && srst_ff, warn_ff && (med_ff == '0))

endmodule

// File: tb/tb.sv
module tb;
   import rmaf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;
   localparam longint Q21_MASK = 64'h1FFFFF;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   range_median_adaptive_ema_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the filter
   int unsigned cfg_speed, cfg_max, cfg_min, cfg_limit, cfg_tmo;
   int unsigned ring_mm [RING_DEPTH];
   int unsigned ring_wr, ring_fill_cnt, warm_cnt, steady_cnt, near_run;
   longint filt_q8, stab_q8;
   bit recov;
   bit [31:0] jump_time, valid_time;

   rsp_type expected_rsp [$];
   int errors = 0;
   int items_sent = 0;
   int stuck_resets = 0;
   int phases = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   bit [31:0] clock_ms;
   int unsigned track_mm;

   function automatic longint round_q16(longint d, int unsigned coef);
      return (d * longint'(coef) + 32768) >>> 16;
   endfunction

   function automatic void ring_restart();
      for (int i = 0; i < RING_DEPTH; i++) ring_mm[i] = cfg_max;
      ring_wr = 0;
      ring_fill_cnt = 0;
   endfunction

   function automatic void shadow_reset();
      cfg_speed = 3; cfg_max = 3500; cfg_min = 30; cfg_limit = 50; cfg_tmo = 5000;
      ring_restart();
      filt_q8 = 3500 * 256;
      stab_q8 = 3500 * 256;
      warm_cnt = 0; recov = 0; steady_cnt = 0;
      jump_time = 0; near_run = 0; valid_time = 0;
   endfunction

   function automatic void track_filter(int unsigned med, bit [31:0] now);
      longint m_q8, s_q8, f_q8, chg;
      int unsigned coef, need;
      bit [31:0] since, tmo;
      m_q8 = longint'(med) * 256;
      s_q8 = stab_q8;
      f_q8 = filt_q8;
      if (warm_cnt < WARMUP_READINGS) begin
         if (med >= cfg_min && med <= cfg_max) begin
            f_q8 = (f_q8 * warm_cnt + m_q8 + (warm_cnt + 1) / 2) / (warm_cnt + 1);
            filt_q8 = f_q8 & Q21_MASK;
            stab_q8 = filt_q8;
            warm_cnt++;
         end
      end else if (m_q8 < s_q8 - 6400 && med < 1500) begin
         recov = 0;
         steady_cnt = 0;
         filt_q8 = m_q8 & Q21_MASK;
         stab_q8 = filt_q8;
      end else begin
         chg = (m_q8 > s_q8) ? m_q8 - s_q8 : s_q8 - m_q8;
         if (m_q8 > s_q8 + 8960 && s_q8 < 204800) begin
            recov = 1;
            jump_time = now;
            steady_cnt = 0;
            if (cfg_speed == 3) f_q8 = m_q8;
            else f_q8 = s_q8 + round_q16(m_q8 - s_q8, cfg_speed == 1 ? 58982 : 62259);
         end else if (chg <= 17920) begin
            coef = 14418;
            if (chg > 5120) coef = 22938;
            else if (chg < 768) coef = 4588;
            if (recov && m_q8 > f_q8)
               coef = cfg_speed == 3 ? 27525 : cfg_speed == 1 ? 16056 : 20644;
            f_q8 = f_q8 + round_q16(m_q8 - f_q8, coef);
            if (chg < 3840) begin
               if (steady_cnt < 255) steady_cnt++;
            end else begin
               steady_cnt = 0;
            end
         end else begin
            coef = cfg_speed == 1 ? 5243 : cfg_speed == 3 ? 11796 : 7864;
            f_q8 = s_q8 + round_q16(m_q8 - s_q8, coef);
            steady_cnt = 0;
         end
         tmo = cfg_speed == 1 ? 3500 : cfg_speed == 3 ? 2000 : 2500;
         need = cfg_speed == 1 ? 6 : cfg_speed == 3 ? 3 : 4;
         since = now - jump_time;
         if (recov && (since > tmo || steady_cnt > need)) recov = 0;
         if (f_q8 > longint'(cfg_max) * 256) f_q8 = longint'(cfg_max) * 256;
         if (f_q8 < longint'(cfg_min) * 256) f_q8 = longint'(cfg_min) * 256;
         filt_q8 = f_q8 & Q21_MASK;
         stab_q8 = filt_q8;
      end
   endfunction

   function automatic rsp_type filter_predict(bit [15:0] raw_in, bit [31:0] now);
      rsp_type r;
      int unsigned raw, near_ref, n, med, key, j;
      int unsigned srt [RING_DEPTH];
      bit [31:0] since;
      raw = raw_in;
      near_ref = cfg_max >= 50 ? cfg_max - 50 : 0;
      r = '0;
      if (raw >= near_ref) begin
         if (near_run < 65535) near_run++;
         if (near_run > cfg_limit) begin
            r.stuck_warning = 1'b1;
            since = now - valid_time;
            if (since > cfg_tmo) begin
               filt_q8 = (longint'(cfg_max) << 8) & Q21_MASK;
               near_run = 0;
               valid_time = now;
               ring_restart();
               r.filtered_q8 = filt_q8[Q8_W-1:0];
               r.sensor_reset = 1'b1;
               r.warming_up = warm_cnt < WARMUP_READINGS;
               return r;
            end
         end
      end else begin
         near_run = 0;
         valid_time = now;
      end
      if (raw > cfg_max) raw = cfg_max;
      ring_mm[ring_wr] = raw;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      if (ring_fill_cnt < RING_DEPTH) ring_fill_cnt++;
      n = ring_fill_cnt;
      med = 0;
      if (n > 0) begin
         for (int i = 0; i < n; i++) srt[i] = ring_mm[i];
         for (int i = 1; i < n; i++) begin
            key = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > key) begin
               srt[j] = srt[j-1];
               j--;
            end
            srt[j] = key;
         end
         med = srt[n >> 1];
      end
      track_filter(med, now);
      r.filtered_q8 = filt_q8[Q8_W-1:0];
      r.median_mm = med[RANGE_W-1:0];
      r.warming_up = warm_cnt < WARMUP_READINGS;
      return r;
   endfunction

   task automatic send_item(bit [15:0] raw, bit [31:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{raw_mm: raw, now_ms: now};
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(filter_predict(raw, now));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, int unsigned value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_SPEED_MODE:  cfg_speed = value & 32'h3;
         CSR_MAX_RANGE:   cfg_max = value & 32'h1FFF;
         CSR_MIN_RANGE:   cfg_min = value & 32'h3FF;
         CSR_STUCK_LIMIT: cfg_limit = value & 32'hFFFF;
         CSR_STUCK_TMO:   cfg_tmo = value & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_all(int unsigned spd, int unsigned mx, int unsigned mn,
                          int unsigned lim, int unsigned tmo);
      write_csr(CSR_SPEED_MODE, spd);
      write_csr(CSR_MAX_RANGE, mx);
      write_csr(CSR_MIN_RANGE, mn);
      write_csr(CSR_STUCK_LIMIT, lim);
      write_csr(CSR_STUCK_TMO, tmo);
      csr_we <= 1'b0;
      phases++;
   endtask

   // warm-up with rejected and extreme samples
   task automatic test_warmup();
      send_item(16'd0, 32'd0);
      send_item(16'hFFFF, 32'd25);
      send_item(16'd1200, 32'd50);
      send_item(16'd1210, 32'd75);
      send_item(16'd5, 32'd100);
      send_item(16'd1190, 32'd125);
      send_item(16'd1205, 32'd150);
      send_item(16'd1201, 32'd175);
      send_item(16'd1199, 32'd200);
      send_item(16'd1202, 32'd225);
      send_item(16'd1203, 32'd250);
      drain();
   endtask

   // obstacle jump, rise from near, ema, slow blend in every speed mode
   task automatic test_modes();
      bit [31:0] t;
      t = 32'd1000;
      for (int spd = 0; spd < 4; spd++) begin
         set_all(spd, 3500, 30, 50, 5000);
         for (int k = 0; k < 5; k++) begin send_item(16'd400, t); t += 30; end
         for (int k = 0; k < 4; k++) begin send_item(16'd2000, t); t += 30; end
         for (int k = 0; k < 3; k++) begin send_item(16'd2050, t); t += 30; end
         for (int k = 0; k < 3; k++) begin send_item(16'd2600, t); t += 3000; end
         drain();
      end
   endtask

   // stuck warning and timeout reset, timestamps wrapping
   task automatic test_stuck();
      set_all(3, 8191, 1023, 2, 100);
      for (int k = 0; k < 6; k++) send_item(16'hFFFF, 32'hFFFF_FF00 + k * 80);
      drain();
      set_all(2, 20, 0, 0, 0);
      for (int k = 0; k < 4; k++) send_item(16'd10, k);
      drain();
      set_all(1, 100, 1023, 65535, 65535);
      for (int k = 0; k < 4; k++) send_item(16'(k * 700), 32'h8000_0000 + k);
      drain();
   endtask

   task automatic test_random();
      int unsigned raw, pick, spd, mx, mn;
      for (int ph = 0; ph < 10; ph++) begin
         calm = ($urandom_range(0, 3) == 0);
         spd = $urandom_range(0, 3);
         pick = $urandom_range(0, 5);
         mx = pick == 0 ? 100 : pick == 1 ? 8191 : $urandom_range(800, 5000);
         pick = $urandom_range(0, 5);
         mn = pick == 0 ? 0 : pick == 1 ? 1023 : $urandom_range(0, 200);
         set_all(spd, mx, mn, $urandom_range(0, 40), $urandom_range(0, 3000));
         clock_ms = $urandom();
         track_mm = $urandom_range(30, mx);
         for (int k = 0; k < 57; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               raw = track_mm + $urandom_range(0, 40);
               raw = raw > 20 ? raw - 20 : raw;
            end else if (pick < 65) begin
               track_mm = $urandom_range(30, 1400);
               raw = track_mm;
            end else if (pick < 75) begin
               track_mm = $urandom_range(30, mx);
               raw = track_mm;
            end else if (pick < 88) begin
               raw = mx + $urandom_range(0, 60);
               raw = raw > 50 ? raw - 50 : raw;
            end else if (pick < 96) begin
               raw = $urandom_range(0, 65535);
            end else begin
               raw = 0;
            end
            pick = $urandom_range(0, 19);
            clock_ms += pick == 0 ? $urandom() : pick == 1 ? $urandom_range(1000, 6000)
                        : $urandom_range(20, 33);
            send_item(raw[15:0], clock_ms);
         end
         drain();
      end
      calm = 1'b0;
   endtask

   // result side
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic void report(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $realtime, field, exp_v, act_v);
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result expected none actual %h", $realtime, rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (e.sensor_reset) stuck_resets++;
            if (rsp_data.filtered_q8 !== e.filtered_q8)
               report("filtered_q8", e.filtered_q8, rsp_data.filtered_q8);
            if (rsp_data.median_mm !== e.median_mm)
               report("median_mm", e.median_mm, rsp_data.median_mm);
            if (rsp_data.stuck_warning !== e.stuck_warning)
               report("stuck_warning", e.stuck_warning, rsp_data.stuck_warning);
            if (rsp_data.sensor_reset !== e.sensor_reset)
               report("sensor_reset", e.sensor_reset, rsp_data.sensor_reset);
            if (rsp_data.warming_up !== e.warming_up)
               report("warming_up", e.warming_up, rsp_data.warming_up);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      shadow_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_warmup();
      test_modes();
      test_stuck();
      test_random();
      drain();
      if (expected_rsp.size() != 0) errors++;
      $display("run covered %0d items over %0d register settings, %0d stuck resets",
               items_sent, phases, stuck_resets);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rmaf_pkg.sv
hw/rtl/range_median_adaptive_ema_filter.sv
tb/tb.sv
